@@ rtl/core/lifegen_pkg.sv @@
// Shared types, constants and cell-rule functions for the row stencil block.
package lifegen_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int ROW_W     = 64;
    localparam int CFG_W     = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] GRID_WIDTH_RESET = 7'd38;

    // Neighbor counts of the B3/S23 rule
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef logic [ROW_W-1:0] t_row;

    // One accepted input row together with the window it sees
    typedef struct packed {
        t_row above;
        t_row middle;
        t_row row;
        logic pending;
        logic last;
    } t_job;

    // Mask of the cells in use for a given width, saturated at MAX_WIDTH
    function automatic t_row width_mask(input logic [CFG_W-1:0] w);
        logic [CFG_W-1:0] ws;
        t_row m;
        ws = (w > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : w;
        if (ws >= CFG_W'(ROW_W)) begin
            m = '1;
        end else begin
            m = (t_row'(1) << ws[5:0]) - t_row'(1);
        end
        return m;
    endfunction

    // Next state of the middle row from its three-row window
    function automatic t_row life_next(input t_row up, input t_row mid,
                                       input t_row down, input t_row mask);
        t_row u_l, u_r, m_l, m_r, d_l, d_r, res;
        logic [3:0] n;
        u_l = (up & mask) << 1;
        u_r = (up & mask) >> 1;
        m_l = (mid & mask) << 1;
        m_r = (mid & mask) >> 1;
        d_l = (down & mask) << 1;
        d_r = (down & mask) >> 1;
        res = '0;
        for (int k = 0; k < ROW_W; k++) begin
            n = 4'(u_l[k]) + 4'(up[k] & mask[k]) + 4'(u_r[k])
              + 4'(m_l[k]) + 4'(m_r[k])
              + 4'(d_l[k]) + 4'(down[k] & mask[k]) + 4'(d_r[k]);
            res[k] = (n == BIRTH_COUNT) || (mid[k] && mask[k] && (n == SURVIVE_COUNT));
        end
        return res & mask;
    endfunction

endpackage

@@ rtl/core/lifegen_if.sv @@
// Handshake channel interfaces: input rows, result rows and width writes.
interface lifegen_row_if;
    import lifegen_pkg::*;
    logic valid;
    logic ready;
    logic [ROW_W-1:0] row_cells;
    logic last_row;
    modport source (output valid, output row_cells, output last_row, input ready);
    modport sink (input valid, input row_cells, input last_row, output ready);
endinterface

interface lifegen_res_if;
    import lifegen_pkg::*;
    logic valid;
    logic ready;
    logic [ROW_W-1:0] next_cells;
    logic last_out;
    modport source (output valid, output next_cells, output last_out, input ready);
    modport sink (input valid, input next_cells, input last_out, output ready);
endinterface

interface lifegen_cfg_if;
    import lifegen_pkg::*;
    logic valid;
    logic ready;
    logic [CFG_W-1:0] grid_width;
    modport source (output valid, output grid_width, input ready);
    modport sink (input valid, input grid_width, output ready);
endinterface

@@ rtl/core/lifegen_front.sv @@
// Front end: width register, row window and classification of accepted rows.
module lifegen_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lifegen_row_if.sink         i_row,
    lifegen_cfg_if.sink         i_cfg,
    input  logic                i_q_full,
    output logic                o_push,
    output lifegen_pkg::t_job   o_job,
    output lifegen_pkg::t_row   o_mask
);
    import lifegen_pkg::*;

    logic [CFG_W-1:0] r_grid_width;
    t_row r_above, n_above;
    t_row r_middle, n_middle;
    logic r_pending, n_pending;
    t_row row_m;
    logic accept;

    assign o_mask      = width_mask(r_grid_width);
    assign i_cfg.ready = 1'b1;
    assign i_row.ready = !i_q_full;
    assign accept      = i_row.valid && i_row.ready;
    assign row_m       = i_row.row_cells & o_mask;

    // Package the row with its window; drop rows that yield no result
    assign o_job = '{above: r_above, middle: r_middle, row: row_m,
                     pending: r_pending, last: i_row.last_row};
    assign o_push = accept && (r_pending || i_row.last_row);

    // Slide the window, or clear it after the last row
    always_comb begin
        n_above   = r_above;
        n_middle  = r_middle;
        n_pending = r_pending;
        if (accept) begin
            if (i_row.last_row) begin
                n_above   = '0;
                n_middle  = '0;
                n_pending = 1'b0;
            end else begin
                n_above   = r_pending ? r_middle : '0;
                n_middle  = row_m;
                n_pending = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= GRID_WIDTH_RESET;
            r_above      <= '0;
            r_middle     <= '0;
            r_pending    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_grid_width <= i_cfg.grid_width;
            end
            r_above   <= n_above;
            r_middle  <= n_middle;
            r_pending <= n_pending;
        end
    end

endmodule

@@ rtl/core/lifegen_queue.sv @@
// Two-entry queue of classified rows between the front and back ends.
module lifegen_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lifegen_pkg::t_job   i_job,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output lifegen_pkg::t_job   o_head
);
    import lifegen_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_full)
        else $error("push into full queue");

endmodule

@@ rtl/core/lifegen_back.sv @@
// Back end: runs the cell rule on queued rows and holds the result register.
module lifegen_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  lifegen_pkg::t_job   i_head,
    input  lifegen_pkg::t_row   i_mask,
    output logic                o_pop,
    lifegen_res_if.source       o_res
);
    import lifegen_pkg::*;

    logic r_phase;
    logic r_out_valid;
    t_row r_out_cells;
    logic r_out_last;
    logic emit_last;
    logic final_item;
    logic load;
    t_row up, mid, down;

    // Pick which of the entry's results goes out this time
    assign emit_last  = !i_head.pending || r_phase;
    assign final_item = emit_last || !i_head.last;
    assign load       = i_q_valid && (!r_out_valid || o_res.ready);
    assign o_pop      = load && final_item;

    assign up   = emit_last ? (i_head.pending ? i_head.middle : '0) : i_head.above;
    assign mid  = emit_last ? i_head.row : i_head.middle;
    assign down = emit_last ? '0 : i_head.row;

    assign o_res.valid      = r_out_valid;
    assign o_res.next_cells = r_out_cells;
    assign o_res.last_out   = r_out_last;

    // Load the result register and track the entry phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_phase     <= !final_item;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_cells <= life_next(up, mid, down, i_mask);
            r_out_last  <= emit_last && i_head.last;
        end
    end

    a_phase_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (i_q_valid && i_head.pending && i_head.last))
        else $error("second phase without a two-result entry");
    a_phase_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_phase) |-> o_pop)
        else $error("second phase did not retire the entry");
    a_last_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && emit_last && i_head.last) |-> o_pop)
        else $error("final row result did not retire its entry");

endmodule

@@ rtl/core/life_generation_row_stencil_unit.sv @@
// Top level of the row-serial B3/S23 generation stencil.
//
// Channels: i_row takes one grid row per item (row_cells, last_row);
// o_res gives result rows (next_cells, last_out); i_cfg writes grid_width
// and is always ready. Cells at or beyond grid_width are dead.
// Each accepted row emits the next state of the row before it, if one is
// held; a last row also emits its own next state flagged with last_out.
// With the queue empty, an accepted item is written into the queue at the
// accepting edge, and its first result is then loaded into the result register
// that drives o_res; a second result of the same entry follows it.
// Throughput: one result per cycle while o_res is ready, set by the single
// result register; rows that emit one result or none are taken every cycle
// while the queue has room; a last row after a held row gives two results.
// Reset empties the queue and window and sets grid_width to 38.
// When o_res stalls, the result holds and the two-entry queue fills, after
// which i_row.ready drops until the receiver takes an item.
module life_generation_row_stencil_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lifegen_row_if.sink     i_row,
    lifegen_cfg_if.sink     i_cfg,
    lifegen_res_if.source   o_res
);
    import lifegen_pkg::*;

    logic q_full, q_valid, push, pop;
    t_job job, head;
    t_row mask;

    lifegen_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (i_row),
        .i_cfg   (i_cfg),
        .i_q_full(q_full),
        .o_push  (push),
        .o_job   (job),
        .o_mask  (mask)
    );

    lifegen_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    lifegen_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_head   (head),
        .i_mask   (mask),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the row-serial B3/S23 generation stencil unit.
`timescale 1ns / 1ps

module testbench;
    import lifegen_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ROWS = 600;

    typedef struct packed {
        t_row cells;
        logic last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    lifegen_row_if row_if ();
    lifegen_cfg_if cfg_if ();
    lifegen_res_if res_if ();

    life_generation_row_stencil_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // Window state mirrored from the accepted items
    logic [CFG_W-1:0] cur_width = GRID_WIDTH_RESET;
    t_row win_above = '0;
    t_row win_middle = '0;
    logic win_held = 1'b0;
    t_result expected_rows[$];

    int mismatches = 0;
    int rows_taken = 0;
    int results_checked = 0;
    int grids_sent = 0;
    int widths_written = 0;
    int cycles = 0;

    // Idling controls for the sender (tx_idle) and the receiver (rx_idle, hold_left)
    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    int hold_left = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_row cells_in_use(input logic [CFG_W-1:0] w);
        int ws;
        ws = (int'(w) > MAX_WIDTH) ? MAX_WIDTH : int'(w);
        if (ws >= ROW_W) begin
            return '1;
        end
        return (t_row'(1) << ws) - t_row'(1);
    endfunction

    // Next state of mid, counting neighbors cell by cell; outside cells are dead
    function automatic t_row evolve(input t_row up, input t_row mid, input t_row down,
                                    input logic [CFG_W-1:0] w);
        t_row m;
        t_row res;
        int n;
        int j;
        m = cells_in_use(w);
        up &= m;
        mid &= m;
        down &= m;
        res = '0;
        for (int k = 0; k < ROW_W; k++) begin
            n = 0;
            for (int dk = -1; dk <= 1; dk++) begin
                j = k + dk;
                if (j >= 0 && j < ROW_W) begin
                    n += int'(up[j]) + int'(down[j]);
                    if (dk != 0) begin
                        n += int'(mid[j]);
                    end
                end
            end
            res[k] = (n == 3) || (mid[k] && n == 2);
        end
        return res & m;
    endfunction

    // Advance the window by one row and queue the rows it completes
    task automatic advance_window(input t_row cells, input logic last);
        t_row r;
        r = cells & cells_in_use(cur_width);
        if (win_held) begin
            expected_rows.push_back('{cells: evolve(win_above, win_middle, r, cur_width),
                                      last: 1'b0});
        end
        if (last) begin
            expected_rows.push_back('{cells: evolve(win_held ? win_middle : '0, r, '0,
                                                    cur_width), last: 1'b1});
            win_above = '0;
            win_middle = '0;
            win_held = 1'b0;
        end else begin
            win_above = win_held ? win_middle : '0;
            win_middle = r;
            win_held = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input t_row got, input t_row want);
        if (mismatches < 20) begin
            $display("Mismatch at result %0d: %s, got %h want %h",
                     results_checked, what, got, want);
        end
        mismatches++;
    endtask

    // Track width writes and rows in, check every result against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (cfg_if.valid && cfg_if.ready) begin
            cur_width = cfg_if.grid_width;
        end
        if (row_if.valid && row_if.ready) begin
            advance_window(row_if.row_cells, row_if.last_row);
            rows_taken++;
        end
        if (res_if.valid && res_if.ready) begin
            if (expected_rows.size() == 0) begin
                report_mismatch("result with nothing expected", res_if.next_cells, '0);
            end else begin
                want = expected_rows.pop_front();
                if (res_if.next_cells !== want.cells) begin
                    report_mismatch("next_cells", res_if.next_cells, want.cells);
                end
                if (res_if.last_out !== want.last) begin
                    report_mismatch("last_out", t_row'(res_if.last_out), t_row'(want.last));
                end
            end
            results_checked++;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Result receiver: a long hold-off while hold_left is set, else random stalls when enabled
    initial begin
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if (rx_idle) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Offer one row and hold it until taken; called at a clock edge
    task automatic send_row(input t_row cells, input logic last);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            row_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        row_if.valid <= 1'b1;
        row_if.row_cells <= cells;
        row_if.last_row <= last;
        @(posedge i_clk);
        while (!row_if.ready) @(posedge i_clk);
        if (last) begin
            grids_sent++;
        end
    endtask

    // Stop offering and wait until every expected row has come back
    task automatic drain();
        row_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_width(input logic [CFG_W-1:0] w);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.grid_width <= w;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        widths_written++;
    endtask

    function automatic t_row pick_row();
        case ($urandom_range(0, 6))
            0: return {$urandom, $urandom};
            1: return {$urandom, $urandom} & {$urandom, $urandom};
            2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            3: return {$urandom, $urandom} | {$urandom, $urandom};
            4: return '0;
            5: return '1;
            default: return t_row'(7) << $urandom_range(0, 63);
        endcase
    endfunction

    // Known shapes at the reset width, edges, bits past the width, single-row grid
    task automatic test_directed();
        send_row('1, 1'b1);
        send_row('0, 1'b0);
        send_row(t_row'(7) << 10, 1'b0);
        send_row('0, 1'b1);
        send_row(t_row'(3) | (t_row'(3) << 36), 1'b0);
        send_row(t_row'(3) | (t_row'(3) << 36), 1'b1);
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        send_row({32{2'b01}}, 1'b0);
        send_row({32{2'b10}}, 1'b1);
        drain();
    endtask

    // Width extremes, saturation above the maximum, and narrow grids
    task automatic test_widths();
        logic [CFG_W-1:0] widths[9];
        widths = '{7'd0, 7'd127, 7'd64, 7'd65, 7'd1, 7'd2, 7'd3, 7'd63, 7'd100};
        foreach (widths[i]) begin
            set_width(widths[i]);
            send_row('1, 1'b0);
            send_row(pick_row(), 1'b0);
            send_row({32{2'b10}}, 1'b1);
        end
        drain();
    endtask

    // Change the width while the window holds rows of an unfinished grid
    task automatic test_width_mid_grid();
        set_width(7'd64);
        send_row('1, 1'b0);
        set_width(7'd10);
        send_row({$urandom, $urandom}, 1'b0);
        send_row('1, 1'b0);
        set_width(7'd50);
        send_row({$urandom, $urandom}, 1'b1);
        drain();
    endtask

    // Hold the receiver off while rows keep coming, so the input stalls
    task automatic test_backpressure();
        set_width(7'd64);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_left = 80;
        for (int i = 0; i < 24; i++) begin
            send_row(pick_row(), (i % 6) == 5);
        end
        drain();
    endtask

    // Random grids of random rows, with idling switched per stretch
    task automatic test_random();
        int sent;
        int len;
        int grid_no;
        sent = 0;
        grid_no = 0;
        while (sent < RANDOM_ROWS) begin
            if (grid_no % 8 == 7) begin
                case ($urandom_range(0, 3))
                    0: set_width(CFG_W'($urandom_range(0, 127)));
                    1: set_width(7'd64);
                    2: set_width(CFG_W'($urandom_range(1, 4)));
                    default: set_width(CFG_W'($urandom_range(1, 64)));
                endcase
            end
            if (grid_no % 5 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
            for (int i = 0; i < len; i++) begin
                send_row(pick_row(), i == len - 1);
            end
            sent += len;
            grid_no++;
        end
        drain();
    endtask

    // Sequence the tests and report
    initial begin
        i_rst_n <= 1'b0;
        row_if.valid <= 1'b0;
        row_if.row_cells <= '0;
        row_if.last_row <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.grid_width <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_widths();
        test_width_mid_grid();
        test_backpressure();
        test_random();

        if (expected_rows.size() != 0) begin
            report_mismatch("expected rows never came", t_row'(expected_rows.size()), '0);
        end
        $display("Covered %0d rows in %0d grids, %0d result rows checked",
                 rows_taken, grids_sent, results_checked);
        $display("Width writes: %0d, including 0, 1, 64 and saturating values; %0d mismatches",
                 widths_written, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ life_generation_row_stencil_unit.f @@
rtl/core/lifegen_pkg.sv
rtl/core/lifegen_if.sv
rtl/core/lifegen_front.sv
rtl/core/lifegen_queue.sv
rtl/core/lifegen_back.sv
rtl/core/life_generation_row_stencil_unit.sv
bench/testbench.sv
